FILE: hw/rtl/vdlc_pkg.sv
`default_nettype none

package vdlc_pkg;

   // Item kinds.
   localparam logic [2:0] KIND_SPEED = 3'd0;
   localparam logic [2:0] KIND_STEER = 3'd1;
   localparam logic [2:0] KIND_BLINK = 3'd2;
   localparam logic [2:0] KIND_TICK  = 3'd3;
   localparam logic [2:0] KIND_FRONT = 3'd4;
   localparam logic [2:0] KIND_REAR  = 3'd5;

   // Control register indexes.
   localparam logic [1:0] REG_DRIVE_MODE   = 2'd0;
   localparam logic [1:0] REG_LIGHT_MODE   = 2'd1;
   localparam logic [1:0] REG_AUTO_LIGHTS  = 2'd2;
   localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

   // Drive modes.
   localparam logic [1:0] DRIVE_SHARED   = 2'd0;
   localparam logic [1:0] DRIVE_SEPARATE = 2'd1;
   localparam logic [1:0] DRIVE_SERVO    = 2'd2;

   // Light modes.
   localparam logic [1:0] LIGHT_OFF        = 2'd0;
   localparam logic [1:0] LIGHT_FRONT      = 2'd1;
   localparam logic [1:0] LIGHT_FRONT_REAR = 2'd2;
   localparam logic [1:0] LIGHT_ALL        = 2'd3;

   // Blinker modes.
   localparam logic [1:0] BLINK_OFF    = 2'd0;
   localparam logic [1:0] BLINK_RIGHT  = 2'd1;
   localparam logic [1:0] BLINK_LEFT   = 2'd2;
   localparam logic [1:0] BLINK_HAZARD = 2'd3;

   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd1000;
   localparam logic [15:0] TICK_MAX           = 16'hFFFF;
   localparam logic [7:0]  SERVO_CENTER       = 8'd90;
   localparam logic [7:0]  LEVEL_MAX          = 8'd255;

   localparam logic signed [10:0] PWM_LIMIT_POS   = 11'sd255;
   localparam logic signed [10:0] PWM_LIMIT_NEG   = -11'sd255;
   localparam logic signed [10:0] SERVO_LIMIT_POS = 11'sd90;
   localparam logic signed [10:0] SERVO_LIMIT_NEG = -11'sd90;
   localparam logic signed [10:0] BLINK_CODE_MAX  = 11'sd3;
   localparam logic signed [10:0] LEVEL_LIMIT     = 11'sd255;

   typedef struct packed {
      logic [1:0]  drive_mode;
      logic [1:0]  light_mode;
      logic        auto_lights;
      logic [15:0] blink_period;
   } vdlc_cfg_type;

   typedef struct packed {
      logic signed [10:0] last_speed;
      logic signed [10:0] last_steer;
      logic [1:0]         signal_mode;
      logic [15:0]        tick_count;
      logic [7:0]         front_lamp;
      logic [7:0]         rear_lamp;
      logic               right_signal;
      logic               left_signal;
      logic [7:0]         motor_one_pwm;
      logic               motor_one_forward;
      logic [7:0]         motor_two_pwm;
      logic               motor_two_forward;
      logic [7:0]         servo_angle;
   } vdlc_state_type;

   localparam vdlc_state_type STATE_RESET = '{
      last_speed:        '0,
      last_steer:        '0,
      signal_mode:       BLINK_OFF,
      tick_count:        '0,
      front_lamp:        '0,
      rear_lamp:         '0,
      right_signal:      1'b0,
      left_signal:       1'b0,
      motor_one_pwm:     '0,
      motor_one_forward: 1'b0,
      motor_two_pwm:     '0,
      motor_two_forward: 1'b0,
      servo_angle:       SERVO_CENTER
   };

endpackage

`default_nettype wire

FILE: hw/rtl/vdlc_step.sv
`default_nettype none

module vdlc_step
   import vdlc_pkg::*;
(
   input  vdlc_cfg_type       cfg,
   input  logic [2:0]         kind,
   input  logic signed [10:0] value,
   input  vdlc_state_type     cur,
   output vdlc_state_type     nxt
);

   logic signed [10:0] spd;
   logic signed [10:0] str;
   logic [7:0]         mag1;
   logic [7:0]         mag2;
   logic               fwd1;
   logic               fwd2;
   logic signed [10:0] str_servo;
   logic signed [10:0] servo_sum;
   logic [7:0]         servo;
   logic [15:0]        tick_base;
   logic               due;
   logic [1:0]         sig_mode;
   logic [7:0]         level;

   assign spd = (kind == KIND_SPEED) ? value : cur.last_speed;
   assign str = (kind == KIND_STEER) ? value : cur.last_steer;

   // Magnitudes saturate at full PWM scale.
   assign mag1 = (spd > PWM_LIMIT_POS || spd < PWM_LIMIT_NEG) ? LEVEL_MAX :
                 (spd < 0) ? 8'(-spd) : spd[7:0];
   assign mag2 = (str > PWM_LIMIT_POS || str < PWM_LIMIT_NEG) ? LEVEL_MAX :
                 (str < 0) ? 8'(-str) : str[7:0];
   assign fwd1 = ~spd[10];
   assign fwd2 = ~str[10];

   assign str_servo = (str > SERVO_LIMIT_POS) ? SERVO_LIMIT_POS :
                      (str < SERVO_LIMIT_NEG) ? SERVO_LIMIT_NEG : str;
   assign servo_sum = str_servo + SERVO_LIMIT_POS;
   assign servo     = servo_sum[7:0];

   // A tick bumps the saturating counter before the due check.
   assign tick_base = (kind == KIND_TICK && cur.tick_count != TICK_MAX) ?
                      cur.tick_count + 16'd1 : cur.tick_count;
   assign due = (tick_base > cfg.blink_period) || (tick_base == TICK_MAX);

   assign sig_mode = (kind != KIND_BLINK) ? cur.signal_mode :
                     (value < 0) ? BLINK_OFF :
                     (value > BLINK_CODE_MAX) ? BLINK_HAZARD : value[1:0];

   assign level = (value < 0) ? 8'd0 :
                  (value > LEVEL_LIMIT) ? LEVEL_MAX : value[7:0];

   always_comb begin
      nxt = cur;
      case (kind) inside
         KIND_SPEED, KIND_STEER: begin
            nxt.last_speed = spd;
            nxt.last_steer = str;
            unique case (cfg.drive_mode)
               DRIVE_SHARED: begin
                  nxt.motor_one_pwm     = mag1;
                  nxt.motor_one_forward = fwd1;
                  nxt.motor_two_pwm     = 8'd0;
                  nxt.motor_two_forward = fwd2;
                  nxt.servo_angle       = SERVO_CENTER;
               end
               DRIVE_SEPARATE: begin
                  nxt.motor_one_pwm     = mag1;
                  nxt.motor_one_forward = fwd1;
                  nxt.motor_two_pwm     = mag2;
                  nxt.motor_two_forward = fwd2;
                  nxt.servo_angle       = SERVO_CENTER;
               end
               DRIVE_SERVO: begin
                  nxt.motor_one_pwm     = mag1;
                  nxt.motor_one_forward = fwd1;
                  nxt.motor_two_pwm     = 8'd0;
                  nxt.motor_two_forward = 1'b0;
                  nxt.servo_angle       = servo;
               end
               default: begin
                  // The unused drive mode leaves the motor outputs alone.
               end
            endcase
            if (cfg.auto_lights && cfg.light_mode != LIGHT_OFF) begin
               nxt.front_lamp = fwd1 ? LEVEL_MAX : 8'd0;
               if (cfg.light_mode == LIGHT_FRONT_REAR || cfg.light_mode == LIGHT_ALL) begin
                  nxt.rear_lamp = fwd1 ? 8'd0 : LEVEL_MAX;
               end
               if (cfg.light_mode == LIGHT_ALL) begin
                  if (mag1 == 8'd0 || mag2 == 8'd0) begin
                     nxt.signal_mode = fwd2 ? BLINK_RIGHT : BLINK_LEFT;
                  end else begin
                     nxt.signal_mode = BLINK_OFF;
                  end
               end
            end
         end
         KIND_BLINK, KIND_TICK: begin
            nxt.tick_count = tick_base;
            if (cfg.light_mode == LIGHT_ALL) begin
               nxt.signal_mode = sig_mode;
               unique case (sig_mode)
                  BLINK_OFF: begin
                     nxt.right_signal = 1'b0;
                     nxt.left_signal  = 1'b0;
                     nxt.tick_count   = '0;
                  end
                  BLINK_RIGHT: begin
                     if (due) begin
                        nxt.right_signal = ~cur.right_signal;
                        nxt.tick_count   = '0;
                     end
                     nxt.left_signal = 1'b0;
                  end
                  BLINK_LEFT: begin
                     if (due) begin
                        nxt.left_signal = ~cur.left_signal;
                        nxt.tick_count  = '0;
                     end
                     nxt.right_signal = 1'b0;
                  end
                  default: begin
                     // Hazard: the left lamp follows the toggled right lamp.
                     if (due) begin
                        nxt.right_signal = ~cur.right_signal;
                        nxt.left_signal  = ~cur.right_signal;
                        nxt.tick_count   = '0;
                     end
                  end
               endcase
            end
         end
         KIND_FRONT: begin
            if (cfg.light_mode != LIGHT_OFF) begin
               nxt.front_lamp = level;
            end
         end
         KIND_REAR: begin
            if (cfg.light_mode == LIGHT_FRONT_REAR || cfg.light_mode == LIGHT_ALL) begin
               nxt.rear_lamp = level;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/vehicle_drive_and_light_control.sv
// Vehicle drive and light control.
// The request channel (req_valid, req_stall, req_kind, req_value) takes one word per
// cycle while req_stall is low: a speed, a steering value, a blinker mode, a timer
// tick or a lamp level. Every request word yields exactly one response word on the
// rsp_ channel, which carries the full set of motor, servo, lamp and signal outputs
// after that word. Control registers are written through csr_wr_en, csr_index and
// csr_wdata; the user must write them only while the block is idle, which the block
// itself does not enforce. They take effect on the next request word.
// A request word is held in an input register; the update logic then loads the state
// registers, which drive the response ports directly, and rsp_valid rises with them.
// One word is taken every cycle unless req_stall is high.
// While rsp_stall holds a response, the input register still takes one more word;
// req_stall rises only when both the input register and the response are held.
// Synchronous reset clears the drive and lamp state (servo centered at 90),
// empties both registers and restores the control registers to their defaults.

`default_nettype none

module vehicle_drive_and_light_control
   import vdlc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata,

   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [2:0]                req_kind,
   input  wire logic signed [10:0]        req_value,

   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [7:0]                rsp_motor_one_pwm,
   output      logic                      rsp_motor_one_forward,
   output      logic [7:0]                rsp_motor_two_pwm,
   output      logic                      rsp_motor_two_forward,
   output      logic [7:0]                rsp_servo_angle,
   output      logic [7:0]                rsp_front_lamp,
   output      logic [7:0]                rsp_rear_lamp,
   output      logic                      rsp_right_signal,
   output      logic                      rsp_left_signal,
   output      logic [1:0]                rsp_blink_state
);

   vdlc_cfg_type       cfg_ff, cfg_in;
   logic               in_valid_ff, in_valid_in;
   logic [2:0]         in_kind_ff;
   logic signed [10:0] in_value_ff;
   vdlc_state_type     state_ff, state_in, state_step;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hold;
   logic               fire;

   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign fire      = in_valid_ff && !rsp_hold;
   assign req_stall = in_valid_ff && rsp_hold;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = fire || rsp_hold;
   assign state_in     = fire ? state_step : state_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DRIVE_MODE:   cfg_in.drive_mode   = csr_wdata[1:0];
            REG_LIGHT_MODE:   cfg_in.light_mode   = csr_wdata[1:0];
            REG_AUTO_LIGHTS:  cfg_in.auto_lights  = csr_wdata[0];
            REG_BLINK_PERIOD: cfg_in.blink_period = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   vdlc_step u_step (
      .cfg   (cfg_ff),
      .kind  (in_kind_ff),
      .value (in_value_ff),
      .cur   (state_ff),
      .nxt   (state_step)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_mode   <= DRIVE_SHARED;
         cfg_ff.light_mode   <= LIGHT_OFF;
         cfg_ff.auto_lights  <= 1'b0;
         cfg_ff.blink_period <= BLINK_PERIOD_RESET;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff            <= STATE_RESET;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload of the input register needs no reset.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_kind_ff  <= req_kind;
         in_value_ff <= req_value;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_motor_one_pwm     = state_ff.motor_one_pwm;
   assign rsp_motor_one_forward = state_ff.motor_one_forward;
   assign rsp_motor_two_pwm     = state_ff.motor_two_pwm;
   assign rsp_motor_two_forward = state_ff.motor_two_forward;
   assign rsp_servo_angle       = state_ff.servo_angle;
   assign rsp_front_lamp        = state_ff.front_lamp;
   assign rsp_rear_lamp         = state_ff.rear_lamp;
   assign rsp_right_signal      = state_ff.right_signal;
   assign rsp_left_signal       = state_ff.left_signal;
   assign rsp_blink_state       = state_ff.signal_mode;

endmodule

`default_nettype wire

FILE: hw/rtl/vdlc_checker.sv
`default_nettype none

module vdlc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_servo_angle
);

   // A held response stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A held response keeps its servo angle.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_servo_angle))
      else $error("servo angle changed while stalled");

   // Once an accepted word has passed the input register, a response (its own or a held one) is on offer.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("no response two cycles after an accepted word");

   // The servo angle never leaves its mechanical range.
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_servo_angle <= 8'd180)
      else $error("servo angle out of range");

endmodule

bind vehicle_drive_and_light_control vdlc_checker u_vdlc_checker (.*);

`default_nettype wire
